// File: rtl/ffca_pkg.sv
`timescale 1ns / 1ps

package ffca_pkg;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_QUERY   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_BADPTR = 2'd2;
   localparam logic [1:0] ST_NULL   = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] request_bytes;
      logic [13:0] pointer;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] payload_offset;
      logic [13:0] payload_bytes;
      logic [14:0] free_now;
      logic [14:0] free_low_mark;
      logic [10:0] live_count;
      logic [31:0] alloc_total;
      logic [31:0] release_total;
      logic [31:0] fail_total;
      logic [31:0] bad_release_total;
   } rsp_type;

   typedef struct packed {
      logic alloc_ok;
      logic alloc_fail;
      logic rel_ok;
      logic rel_bad;
   } stats_upd_type;

endpackage

// File: rtl/ffca_hdr_mem.sv
`timescale 1ns / 1ps

module ffca_hdr_mem #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule

// File: rtl/ffca_stats.sv
`timescale 1ns / 1ps

module ffca_stats #(
   parameter int SIZE_W    = 15,
   parameter int FREE_INIT = 16376
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 upd_en,
   input  ffca_pkg::stats_upd_type upd,
   input  logic [SIZE_W-1:0]    amount,
   output logic [SIZE_W-1:0]    free_ff,
   output logic [SIZE_W-1:0]    low_ff,
   output logic [10:0]          live_ff,
   output logic [31:0]          alloc_cnt_ff,
   output logic [31:0]          rel_cnt_ff,
   output logic [31:0]          fail_cnt_ff,
   output logic [31:0]          bad_cnt_ff
);

   logic [SIZE_W-1:0] free_sub;

   assign free_sub = free_ff - amount;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= SIZE_W'(FREE_INIT);
         low_ff       <= SIZE_W'(FREE_INIT);
         live_ff      <= '0;
         alloc_cnt_ff <= '0;
         rel_cnt_ff   <= '0;
         fail_cnt_ff  <= '0;
         bad_cnt_ff   <= '0;
      end else if (upd_en) begin
         if (upd.alloc_ok) begin
            free_ff      <= free_sub;
            if (free_sub < low_ff) begin
               low_ff <= free_sub;
            end
            live_ff      <= live_ff + 11'd1;
            alloc_cnt_ff <= alloc_cnt_ff + 32'd1;
         end
         if (upd.alloc_fail) begin
            fail_cnt_ff <= fail_cnt_ff + 32'd1;
         end
         if (upd.rel_ok) begin
            free_ff    <= free_ff + amount;
            live_ff    <= live_ff - 11'd1;
            rel_cnt_ff <= rel_cnt_ff + 32'd1;
         end
         if (upd.rel_bad) begin
            bad_cnt_ff <= bad_cnt_ff + 32'd1;
         end
      end
   end

endmodule

// File: rtl/first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
// channel | direction | ports                        | transfer when
// req     | in        | req_valid req_stall req_data | req_valid && !req_stall
// rsp     | out       | rsp_valid rsp_stall rsp_data | rsp_valid && !rsp_stall
//
// one request at a time; header memories have one port each and a registered read
// alloc walks the free list from its head and takes the first block big enough; a failed
// alloc walks the whole list; a split then files the remainder back on the free list;
// release files the freed block in address order and merges it with the previous and
// next free blocks where they are adjacent; query, null, bad range and unused action
// do not change the free list
// after reset a clearing pass writes every header entry,
// with req_stall high
// a new request is taken while a finished response still waits on rsp_stall; its own
// response then waits in the output state
// ALIGN_BYTES is taken as a power of two

module first_fit_coalescing_allocator #(
   parameter int POOL_BYTES   = 16384,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffca_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffca_pkg::rsp_type rsp_data
);

   localparam int HDR       = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int MIN_BLOCK = 2 * HDR;
   localparam int DEPTH     = POOL_BYTES / ALIGN_BYTES;
   localparam int END_OFF   = ((POOL_BYTES - HDR) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int END_IDX   = END_OFF / ALIGN_BYTES;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int SIZE_W    = $clog2(POOL_BYTES + 1);
   localparam int AL_SH     = $clog2(ALIGN_BYTES);
   localparam int CW        = (SIZE_W > 18) ? SIZE_W : 18;
   localparam int BW        = $clog2(POOL_BYTES) + 2;
   localparam int WORD_W    = SIZE_W + 1;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_A_CHK, S_A_RD, S_A_UNL, S_A_MARK,
      S_P_CHK, S_P_RD,
      S_I_START, S_I_CHK, S_I_RD, S_I_MP, S_I_MN, S_I_MNR, S_I_LNK,
      S_FIN, S_OUT
   } state_type;

   state_type state_ff;

   logic [1:0]        act_ff;
   logic [13:0]       ptr_ff;
   logic [CW-1:0]     need_ff;
   logic [IDX_W-1:0]  head_ff, prev_ff, b_ff, blink_ff, it_ff, g_ff, nxt_ff, clr_ff;
   logic              prev_head_ff, it_start_ff, mp_ff, split_ff;
   logic [SIZE_W-1:0] bsize_ff, it_size_ff, gsz_ff, amt_ff;
   logic [1:0]        status_ff;
   logic [13:0]       offset_ff, psize_ff;
   ffca_pkg::stats_upd_type upd_ff;
   logic              rsp_valid_ff;
   ffca_pkg::rsp_type rsp_ff;

   logic              sz_we, lk_we;
   logic [IDX_W-1:0]  sz_addr, lk_addr;
   logic [WORD_W-1:0] sz_wdata, sz_rd;
   logic [IDX_W-1:0]  lk_wdata, lk_rd;

   logic [SIZE_W-1:0] free_ff, low_ff;
   logic [10:0]       live_ff;
   logic [31:0]       alloc_cnt_ff, rel_cnt_ff, fail_cnt_ff, bad_cnt_ff;

   function automatic logic [IDX_W-1:0] link_of(input logic [IDX_W-1:0] x);
      logic [IDX_W:0] wide;
      wide = {1'b0, x};
      return (wide < (IDX_W + 1)'(DEPTH)) ? x : IDX_W'(END_IDX);
   endfunction

   // request size plus header, rounded to alignment, at least two headers
   logic [17:0] need_raw, need_min;
   assign need_raw = (18'(req_data.request_bytes) + 18'(HDR) + 18'(ALIGN_BYTES - 1))
                     & ~18'(ALIGN_BYTES - 1);
   assign need_min = (need_raw < 18'(MIN_BLOCK)) ? 18'(MIN_BLOCK) : need_raw;

   logic [SIZE_W-1:0] need_s, rest;
   logic              split_now;
   logic [IDX_W-1:0]  split_idx;
   assign need_s    = SIZE_W'(need_ff);
   assign rest      = bsize_ff - need_s;
   assign split_now = rest >= SIZE_W'(MIN_BLOCK);
   assign split_idx = b_ff + IDX_W'(need_s >> AL_SH);

   // pointer checks
   logic [31:0]      ptr_w;
   logic             ptr_bad;
   logic [IDX_W-1:0] ptr_g;
   assign ptr_w   = {18'd0, ptr_ff};
   assign ptr_bad = (ptr_w < 32'(HDR)) || (ptr_w >= 32'(END_OFF))
                    || ((ptr_w & 32'(ALIGN_BYTES - 1)) != 32'd0);
   assign ptr_g   = IDX_W'((ptr_w - 32'(HDR)) >> AL_SH);

   logic [SIZE_W-1:0] rd_size;
   assign rd_size = sz_rd[SIZE_W-1:0];

   logic merge_prev, adj_next;
   assign merge_prev = !it_start_ff &&
      ((BW'(it_ff) << AL_SH) + BW'(it_size_ff) == (BW'(g_ff) << AL_SH));
   assign adj_next = ((BW'(g_ff) << AL_SH) + BW'(gsz_ff) == (BW'(nxt_ff) << AL_SH));

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sz_we    = 1'b0;
      lk_we    = 1'b0;
      sz_addr  = b_ff;
      lk_addr  = b_ff;
      sz_wdata = '0;
      lk_wdata = '0;
      unique case (state_ff)
         S_CLR: begin
            sz_we    = 1'b1;
            lk_we    = 1'b1;
            sz_addr  = clr_ff;
            lk_addr  = clr_ff;
            sz_wdata = (clr_ff == '0) ? WORD_W'(END_OFF) : '0;
            lk_wdata = (clr_ff == '0) ? IDX_W'(END_IDX) : '0;
         end
         S_A_UNL: begin
            lk_we    = !prev_head_ff;
            lk_addr  = prev_ff;
            lk_wdata = blink_ff;
            sz_we    = 1'b1;
            sz_wdata = {1'b1, split_now ? need_s : bsize_ff};
         end
         S_A_MARK: begin
            lk_we    = 1'b1;
            lk_wdata = IDX_W'(END_IDX);
            sz_we    = split_ff;
            sz_addr  = split_idx;
            sz_wdata = {1'b0, rest};
         end
         S_P_CHK: begin
            sz_addr = ptr_g;
            lk_addr = ptr_g;
         end
         S_P_RD: begin
            sz_addr  = g_ff;
            lk_addr  = g_ff;
            sz_we    = (act_ff == ffca_pkg::ACT_RELEASE) && sz_rd[SIZE_W];
            lk_we    = sz_we;
            sz_wdata = {1'b0, rd_size};
            lk_wdata = IDX_W'(END_IDX);
         end
         S_I_CHK: begin
            sz_addr = nxt_ff;
            lk_addr = nxt_ff;
         end
         S_I_MP: begin
            sz_we    = merge_prev;
            sz_addr  = it_ff;
            sz_wdata = {1'b0, it_size_ff + gsz_ff};
         end
         S_I_MN: begin
            sz_addr  = nxt_ff;
            lk_addr  = (adj_next && nxt_ff != IDX_W'(END_IDX)) ? nxt_ff : g_ff;
            lk_we    = !(adj_next && nxt_ff != IDX_W'(END_IDX));
            lk_wdata = adj_next ? IDX_W'(END_IDX) : nxt_ff;
         end
         S_I_MNR: begin
            sz_we    = 1'b1;
            lk_we    = 1'b1;
            sz_addr  = g_ff;
            lk_addr  = g_ff;
            sz_wdata = {1'b0, gsz_ff + rd_size};
            lk_wdata = link_of(lk_rd);
         end
         S_I_LNK: begin
            lk_we    = !mp_ff && !it_start_ff;
            lk_addr  = it_ff;
            lk_wdata = g_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         upd_ff       <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + IDX_W'(1);
               if (clr_ff == IDX_W'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  act_ff       <= req_data.action;
                  ptr_ff       <= req_data.pointer;
                  need_ff      <= CW'(need_min);
                  prev_head_ff <= 1'b1;
                  b_ff         <= link_of(head_ff);
                  offset_ff    <= '0;
                  psize_ff     <= '0;
                  mp_ff        <= 1'b0;
                  split_ff     <= 1'b0;
                  upd_ff       <= '0;
                  state_ff     <= (req_data.action == ffca_pkg::ACT_ALLOC) ? S_A_CHK
                                                                           : S_P_CHK;
               end
            end
            S_A_CHK: begin
               if (b_ff == IDX_W'(END_IDX)) begin
                  status_ff         <= ffca_pkg::ST_NOFIT;
                  upd_ff.alloc_fail <= 1'b1;
                  state_ff          <= S_FIN;
               end else begin
                  state_ff <= S_A_RD;
               end
            end
            S_A_RD: begin
               if (CW'(sz_rd) < need_ff) begin
                  prev_ff      <= b_ff;
                  prev_head_ff <= 1'b0;
                  b_ff         <= link_of(lk_rd);
                  state_ff     <= S_A_CHK;
               end else begin
                  bsize_ff <= rd_size;
                  blink_ff <= link_of(lk_rd);
                  state_ff <= S_A_UNL;
               end
            end
            S_A_UNL: begin
               if (prev_head_ff) begin
                  head_ff <= blink_ff;
               end
               split_ff  <= split_now;
               amt_ff    <= split_now ? need_s : bsize_ff;
               gsz_ff    <= rest;
               g_ff      <= split_idx;
               status_ff <= ffca_pkg::ST_OK;
               offset_ff <= 14'((32'(b_ff) << AL_SH) + 32'(HDR));
               upd_ff.alloc_ok <= 1'b1;
               state_ff  <= S_A_MARK;
            end
            S_A_MARK: begin
               state_ff <= split_ff ? S_I_START : S_FIN;
            end
            S_P_CHK: begin
               g_ff <= ptr_g;
               if (act_ff != ffca_pkg::ACT_RELEASE && act_ff != ffca_pkg::ACT_QUERY) begin
                  status_ff <= ffca_pkg::ST_BADPTR;
                  state_ff  <= S_FIN;
               end else if (ptr_ff == '0) begin
                  status_ff <= ffca_pkg::ST_NULL;
                  state_ff  <= S_FIN;
               end else if (ptr_bad) begin
                  status_ff      <= ffca_pkg::ST_BADPTR;
                  upd_ff.rel_bad <= (act_ff == ffca_pkg::ACT_RELEASE);
                  state_ff       <= S_FIN;
               end else begin
                  state_ff <= S_P_RD;
               end
            end
            S_P_RD: begin
               if (!sz_rd[SIZE_W]) begin
                  status_ff      <= ffca_pkg::ST_BADPTR;
                  upd_ff.rel_bad <= (act_ff == ffca_pkg::ACT_RELEASE);
                  state_ff       <= S_FIN;
               end else if (act_ff == ffca_pkg::ACT_QUERY) begin
                  status_ff <= ffca_pkg::ST_OK;
                  psize_ff  <= 14'(rd_size - SIZE_W'(HDR));
                  state_ff  <= S_FIN;
               end else begin
                  status_ff <= ffca_pkg::ST_OK;
                  amt_ff    <= rd_size;
                  gsz_ff    <= rd_size;
                  upd_ff.rel_ok <= 1'b1;
                  state_ff  <= S_I_START;
               end
            end
            S_I_START: begin
               it_start_ff <= 1'b1;
               nxt_ff      <= link_of(head_ff);
               state_ff    <= S_I_CHK;
            end
            S_I_CHK: begin
               if (nxt_ff < g_ff && nxt_ff != IDX_W'(END_IDX)) begin
                  state_ff <= S_I_RD;
               end else begin
                  state_ff <= S_I_MP;
               end
            end
            S_I_RD: begin
               it_ff       <= nxt_ff;
               it_start_ff <= 1'b0;
               it_size_ff  <= rd_size;
               nxt_ff      <= link_of(lk_rd);
               state_ff    <= S_I_CHK;
            end
            S_I_MP: begin
               if (merge_prev) begin
                  g_ff   <= it_ff;
                  gsz_ff <= it_size_ff + gsz_ff;
                  mp_ff  <= 1'b1;
               end
               state_ff <= S_I_MN;
            end
            S_I_MN: begin
               state_ff <= (adj_next && nxt_ff != IDX_W'(END_IDX)) ? S_I_MNR : S_I_LNK;
            end
            S_I_MNR: begin
               state_ff <= S_I_LNK;
            end
            S_I_LNK: begin
               if (!mp_ff && it_start_ff) begin
                  head_ff <= g_ff;
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.status            <= status_ff;
                  rsp_ff.payload_offset    <= (status_ff == ffca_pkg::ST_OK) ? offset_ff : '0;
                  rsp_ff.payload_bytes     <= psize_ff;
                  rsp_ff.free_now          <= 15'(free_ff);
                  rsp_ff.free_low_mark     <= 15'(low_ff);
                  rsp_ff.live_count        <= live_ff;
                  rsp_ff.alloc_total       <= alloc_cnt_ff;
                  rsp_ff.release_total     <= rel_cnt_ff;
                  rsp_ff.fail_total        <= fail_cnt_ff;
                  rsp_ff.bad_release_total <= bad_cnt_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // stats update happens once, in the finishing state
   logic stats_en;
   ffca_pkg::stats_upd_type stats_upd;
   logic [SIZE_W-1:0] stats_amt;
   assign stats_en  = (state_ff == S_FIN);
   assign stats_amt = amt_ff;
   assign stats_upd = upd_ff;

   ffca_hdr_mem #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_size_mem (
      .clock    (clock),
      .we       (sz_we),
      .addr     (sz_addr),
      .wdata    (sz_wdata),
      .rdata_ff (sz_rd)
   );

   ffca_hdr_mem #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_link_mem (
      .clock    (clock),
      .we       (lk_we),
      .addr     (lk_addr),
      .wdata    (lk_wdata),
      .rdata_ff (lk_rd)
   );

   ffca_stats #(.SIZE_W(SIZE_W), .FREE_INIT(END_OFF)) u_stats (
      .clock        (clock),
      .reset        (reset),
      .upd_en       (stats_en),
      .upd          (stats_upd),
      .amount       (stats_amt),
      .free_ff      (free_ff),
      .low_ff       (low_ff),
      .live_ff      (live_ff),
      .alloc_cnt_ff (alloc_cnt_ff),
      .rel_cnt_ff   (rel_cnt_ff),
      .fail_cnt_ff  (fail_cnt_ff),
      .bad_cnt_ff   (bad_cnt_ff)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("request transfer did not start work");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response loaded outside output state");

   a_insert_not_self: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_I_MN) |-> (nxt_ff != g_ff))
      else $error("freed block found on free list");

   a_stats_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> (state_ff == S_OUT))
      else $error("finish state not followed by output state");

endmodule
